// File: hw/rtl/small_set_store_core_defines.svh
// Assertion macros for the small set store.
`ifndef SMALL_SET_STORE_CORE_DEFINES_SVH
`define SMALL_SET_STORE_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk while out of reset.
`define SSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("small_set_store_core: same-cycle check failed");

// Next-cycle implication, checked on clk while out of reset.
`define SSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("small_set_store_core: next-cycle check failed");

`endif

// File: hw/rtl/sss_pkg.sv
// Shared types and constants for the small set store.
package sss_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 4;
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef struct packed {
        logic              update;
        cmd_t              cmd;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

// File: hw/rtl/small_set_store_core.sv
// Top level of the small set store: command register, cell chain, count and result registers.
// Sequence: an accepted command sets pending_reg (busy); the compare then loads done_reg and the result registers.
// A new command is not accepted while busy is high; busy is high for the cycle the cell chain compares.
// The compare, hit chain and shift-down all complete in that single cycle.
// Reset: asynchronous, active low; clears the count and control, entry data is not reset.
// The receiver cannot stall: each result is shown for one cycle with done high.
`include "small_set_store_core_defines.svh"

module small_set_store_core import sss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic signed [DATA_W-1:0] value,
    input  logic [IDX_W-1:0]         index,
    output logic                     done,
    output logic [2:0]               status,
    output logic                     found,
    output logic [CNT_W-1:0]         count,
    output logic signed [DATA_W-1:0] read_data
);

    logic              pending_reg;
    logic              done_reg;
    cmd_t              cmd_reg;
    logic [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    status_t           status_reg;
    status_t           status_next;
    logic              found_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] rdata_next;

    cell_ctl_t         ctl;
    logic [CAPACITY:0] hit;
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic              hit_any;
    logic              full;
    logic              idx_ok;
    logic [DATA_W-1:0] rd_mux;
    logic              accept;

    assign accept  = start && !pending_reg;
    assign busy    = pending_reg;
    assign hit[0]  = 1'b0;
    assign hit_any = hit[CAPACITY];
    assign full    = (count_reg >= CNT_W'(CAPACITY));
    assign idx_ok  = (CMP_W'(index_reg) < CMP_W'(count_reg));

    assign ctl.update = pending_reg;
    assign ctl.cmd    = cmd_reg;
    assign ctl.value  = value_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] right;
        if (i == CAPACITY - 1)
        begin : g_last
            assign right = cell_data[i];
        end
        else
        begin : g_mid
            assign right = cell_data[i+1];
        end

        sss_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .valid_in   (CNT_W'(i) < count_reg),
            .ins_here   ((cmd_reg == CMD_INSERT) && !hit_any && !full
                         && (count_reg == CNT_W'(i))),
            .hit_in     (hit[i]),
            .right_data (right),
            .hit_out    (hit[i+1]),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CMP_W'(index_reg) == CMP_W'(i))
            begin
                rd_mux = cell_data[i];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        rdata_next  = '0;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (hit_any)
                begin
                    status_next = ST_PRESENT;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (!hit_any)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_QUERY:
            begin
                status_next = ST_OK;
            end
            CMD_READ:
            begin
                if (idx_ok)
                begin
                    rdata_next = rd_mux;
                end
                else
                begin
                    status_next = ST_BAD_INDEX;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            pending_reg <= accept;
            done_reg    <= pending_reg;
            if (pending_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(command);
            value_reg <= value;
            index_reg <= index;
        end
        if (pending_reg)
        begin
            status_reg <= status_next;
            found_reg  <= hit_any;
            rdata_reg  <= rdata_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign count     = count_reg;
    assign read_data = rdata_reg;

    `SSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SSS_ASSERT_NEXT(a_busy_done, busy, done && !busy)
    `SSS_ASSERT_IMPL(a_full_count, done && (status_reg == ST_FULL), count_reg == CNT_W'(CAPACITY))
    `SSS_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SSS_ASSERT_IMPL(a_found_status, done && (status_reg == ST_PRESENT), found_reg)

endmodule

// File: hw/rtl/sss_cell.sv
// One storage cell of the set chain: compare, hit propagation, shift-down and insert.
module sss_cell import sss_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic              valid_in,
    input  logic              ins_here,
    input  logic              hit_in,
    input  logic [DATA_W-1:0] right_data,
    output logic              hit_out,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match;

    assign match   = valid_in && (data_reg == ctl.value);
    assign hit_out = hit_in | match;
    assign data    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.update && (ctl.cmd == CMD_REMOVE) && hit_out)
        begin
            data_next = right_data;
        end
        else if (ctl.update && ins_here)
        begin
            data_next = ctl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: dv/sss_reply_checker.sv
`timescale 1ns / 1ps
// Reply checker for the small set store: tracks the set, predicts each reply, compares.
module sss_reply_checker import sss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               command,
    input  logic signed [DATA_W-1:0] value,
    input  logic [IDX_W-1:0]         index,
    input  logic                     done,
    input  logic [2:0]               status,
    input  logic                     found,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [DATA_W-1:0] read_data,
    output int                       fail_count,
    output int                       outstanding
);

    typedef struct {
        status_t           status;
        logic              found;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] read_data;
    } set_reply_t;

    logic [DATA_W-1:0] members [CAPACITY];
    int                member_total;
    set_reply_t        reply_q [$];

    function automatic set_reply_t set_outcome(cmd_t cmd, logic [DATA_W-1:0] v,
                                               logic [IDX_W-1:0] idx);
        set_reply_t r;
        int         pos;
        pos = -1;
        for (int i = 0; i < member_total; i++)
            if (pos < 0 && members[i] == v)
                pos = i;
        r.status    = ST_OK;
        r.found     = (pos >= 0);
        r.read_data = '0;
        case (cmd)
            CMD_INSERT:
                if (pos >= 0)
                    r.status = ST_PRESENT;
                else if (member_total >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    members[member_total] = v;
                    member_total++;
                end
            CMD_REMOVE:
                if (pos < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int j = pos; j + 1 < member_total; j++)
                        members[j] = members[j + 1];
                    member_total--;
                end
            CMD_QUERY:
                r.status = ST_OK;
            default:
                if (int'(idx) < member_total)
                    r.read_data = members[idx];
                else
                    r.status = ST_BAD_INDEX;
        endcase
        r.count = CNT_W'(member_total);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        set_reply_t want;
        if (!rst_n)
        begin
            member_total = 0;
            reply_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (reply_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t unexpected reply: status %0d found %0b count %0d data %h",
                                 $realtime, status, found, count, read_data);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (status !== want.status || found !== want.found ||
                        count !== want.count || read_data !== want.read_data)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("%t reply mismatch: exp status %0d found %0b count %0d data %h, ",
                                   $realtime, want.status, want.found, want.count,
                                   want.read_data);
                            $display("got status %0d found %0b count %0d data %h",
                                     status, found, count, read_data);
                        end
                    end
                end
            end
            if (start && !busy)
                reply_q.push_back(set_outcome(cmd_t'(command), value, index));
            outstanding = reply_q.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the small set store: clock, reset, command stimulus and verdict.
module testbench;
    import sss_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     done;
    logic [2:0]               status;
    logic                     found;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] read_data;
    int                       fail_count;
    int                       outstanding;

    int                idle_pct;
    logic [DATA_W-1:0] value_pool [20];
    logic [DATA_W-1:0] recent_inserts [$];

    small_set_store_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .value(value), .index(index),
        .done(done), .status(status), .found(found), .count(count), .read_data(read_data)
    );

    sss_reply_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .value(value), .index(index),
        .done(done), .status(status), .found(found), .count(count), .read_data(read_data),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // one command transfer; start stays high unless an idle gap follows
    task automatic issue(cmd_t c, logic [DATA_W-1:0] v, logic [IDX_W-1:0] i);
        start   = 1'b1;
        command = c;
        value   = v;
        index   = i;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (c == CMD_INSERT)
        begin
            recent_inserts.push_back(v);
            if (recent_inserts.size() > 24)
                void'(recent_inserts.pop_front());
        end
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                r;
        int                insert_w;
        cmd_t              c;
        logic [DATA_W-1:0] v;
        rst_n    = 1'b0;
        start    = 1'b0;
        command  = CMD_INSERT;
        value    = '0;
        index    = '0;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty set
        issue(CMD_QUERY, 32'h0, 4'd0);
        issue(CMD_READ, 32'h0, 4'd0);
        issue(CMD_REMOVE, 32'h8000_0000, 4'd0);
        // first insert, duplicate, membership
        issue(CMD_INSERT, 32'h8000_0000, 4'd0);
        issue(CMD_INSERT, 32'h8000_0000, 4'd0);
        issue(CMD_QUERY, 32'h8000_0000, 4'd0);
        issue(CMD_READ, 32'h0, 4'd0);
        issue(CMD_READ, 32'h7fff_ffff, 4'd1);
        // fill to capacity
        for (int k = 1; k < CAPACITY; k++)
        begin
            if (k == 1)
                v = 32'h7fff_ffff;
            else if (k == 2)
                v = 32'h0;
            else if (k == 3)
                v = 32'hffff_ffff;
            else
                v = ($urandom & 32'hffff_fff0) | k;
            issue(CMD_INSERT, v, 4'(k));
        end
        issue(CMD_INSERT, 32'h1234_5671, 4'd0);
        issue(CMD_INSERT, 32'h0, 4'd0);
        issue(CMD_READ, 32'h0, 4'd15);
        // remove the head, then the entry that moved into its place
        issue(CMD_REMOVE, 32'h8000_0000, 4'd15);
        issue(CMD_REMOVE, 32'h7fff_ffff, 4'd0);
        issue(CMD_READ, 32'hffff_ffff, 4'd15);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 31 : (phase == 1) ? 66 : 0;
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7fff_ffff;
            value_pool[2] = 32'h0;
            value_pool[3] = 32'hffff_ffff;
            for (int p = 4; p < 20; p++)
                value_pool[p] = $urandom;
            for (int seg = 0; seg < 4; seg++)
            begin
                insert_w = $urandom_range(20, 50);
                repeat (84)
                begin
                    r = $urandom_range(0, 99);
                    if (r < insert_w)
                        c = CMD_INSERT;
                    else if (r < insert_w + 25)
                        c = CMD_REMOVE;
                    else if (r < insert_w + 35)
                        c = CMD_QUERY;
                    else
                        c = CMD_READ;
                    r = $urandom_range(0, 99);
                    if (c != CMD_INSERT && recent_inserts.size() != 0 && r < 60)
                        v = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
                    else if (r < 80)
                        v = value_pool[$urandom_range(0, 19)];
                    else
                        v = $urandom;
                    issue(c, v, 4'($urandom_range(0, 15)));
                end
            end
            drain();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sss_pkg.sv
hw/rtl/sss_cell.sv
hw/rtl/small_set_store_core.sv
dv/sss_reply_checker.sv
dv/testbench.sv
